// ----- design/pic_pkg.sv -----
// Shared constants, codes and types for the point-in-cylinder-sector test.
package pic_pkg;

    localparam int COORD_WIDTH_DEF = 20;
    localparam int ANGLE_BITS_DEF  = 16;
    localparam int TOL_W           = 16;
    localparam int ROT_FRAC        = 14;
    localparam int CORDIC_STEPS    = 30;
    localparam int INV_W           = 30;
    localparam logic [INV_W-1:0] INV_TWO_PI_Q32 = 30'd683565276;

    // configuration register indexes
    localparam logic [2:0] REG_ROW0    = 3'd0;
    localparam logic [2:0] REG_ROW1    = 3'd1;
    localparam logic [2:0] REG_ROW2    = 3'd2;
    localparam logic [2:0] REG_OFFSET  = 3'd3;
    localparam logic [2:0] REG_RADIUS  = 3'd4;
    localparam logic [2:0] REG_AXIAL   = 3'd5;
    localparam logic [2:0] REG_SECTOR  = 3'd6;
    localparam logic [2:0] REG_EXCLUDE = 3'd7;

    // verdict codes
    localparam logic [1:0] V_INSIDE  = 2'd0;
    localparam logic [1:0] V_RADIAL  = 2'd1;
    localparam logic [1:0] V_AXIAL   = 2'd2;
    localparam logic [1:0] V_ANGULAR = 2'd3;

    // status that rides alongside the angle chain
    typedef struct packed {
        logic [1:0] verdict;
        logic       tol_neg;
        logic       tol_zero;
        logic       sat;
    } t_side;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic [31:0] atan_turn(input int idx);
        case (idx)
            0:  return 32'd536870912;
            1:  return 32'd316933406;
            2:  return 32'd167458907;
            3:  return 32'd85004756;
            4:  return 32'd42667331;
            5:  return 32'd21354465;
            6:  return 32'd10679838;
            7:  return 32'd5340245;
            8:  return 32'd2670163;
            9:  return 32'd1335087;
            10: return 32'd667544;
            11: return 32'd333772;
            12: return 32'd166886;
            13: return 32'd83443;
            14: return 32'd41722;
            15: return 32'd20861;
            16: return 32'd10430;
            17: return 32'd5215;
            18: return 32'd2608;
            19: return 32'd1304;
            20: return 32'd652;
            21: return 32'd326;
            22: return 32'd163;
            23: return 32'd81;
            24: return 32'd41;
            25: return 32'd20;
            26: return 32'd10;
            27: return 32'd5;
            28: return 32'd3;
            29: return 32'd1;
            default: return 32'd0;
        endcase
    endfunction

endpackage

// ----- design/pic_front.sv -----
// Front pipeline: frame transform, radial and axial tests, angle chain set-up.
module pic_front #(
    parameter int CW = pic_pkg::COORD_WIDTH_DEF,
    parameter int AB = pic_pkg::ANGLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [CW-1:0]     i_px,
    input  logic signed [CW-1:0]     i_py,
    input  logic signed [CW-1:0]     i_pz,
    input  logic signed [15:0]       i_tol,
    input  logic [47:0]              i_row0,
    input  logic [47:0]              i_row1,
    input  logic [47:0]              i_row2,
    input  logic [3*CW-1:0]          i_offset,
    input  logic [CW-2:0]            i_radius,
    input  logic [2*CW-1:0]          i_axial,
    input  logic                     i_exclude,
    output logic                     o_valid,
    output logic signed [CW+5:0]     o_x,
    output logic signed [CW+5:0]     o_y,
    output logic [31:0]              o_acc,
    output logic [AB+13:0]           o_rem,
    output pic_pkg::t_side           o_side
);
    import pic_pkg::*;

    localparam int PW  = CW + 16;
    localparam int SW  = CW + 18;
    localparam int LW  = CW + 3;
    localparam int KW  = CW + 6;
    localparam int NW  = TOL_W + INV_W;
    localparam int DW  = AB + 14;
    localparam int QB  = AB + 3;
    localparam int XW  = DW + CW;
    localparam int TW  = ((CW - 1 > 16) ? CW - 1 : 16) + 2;
    localparam int MW  = (LW > TW - 1) ? LW : TW - 1;
    localparam int QW  = 2 * (TW - 1);
    localparam int EW  = ((LW > 17) ? LW : 17) + 2;
    localparam logic signed [SW-1:0] HALF = SW'(1 << (ROT_FRAC - 1));

    logic [47:0] rows [3];
    logic signed [CW-1:0] offs [3];
    assign rows[0] = i_row0;
    assign rows[1] = i_row1;
    assign rows[2] = i_row2;
    assign offs[0] = $signed(i_offset[CW-1:0]);
    assign offs[1] = $signed(i_offset[2*CW-1:CW]);
    assign offs[2] = $signed(i_offset[3*CW-1:2*CW]);

    // stage A: input capture, tolerance sign
    logic                 r_a_v;
    logic signed [CW-1:0] r_a_p [3];
    logic signed [16:0]   r_a_tol;
    logic signed [16:0]   tol_ext;
    assign tol_ext = 17'(i_tol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_p[0] <= i_px;
            r_a_p[1] <= i_py;
            r_a_p[2] <= i_pz;
            r_a_tol  <= i_exclude ? tol_ext : -tol_ext;
        end
    end

    // stage B: rotation products, tolerance times 1/(2 pi)
    logic                 r_b_v;
    logic signed [PW-1:0] r_b_prod [9];
    logic [NW-1:0]        r_b_n;
    logic signed [16:0]   r_b_tol;
    logic signed [16:0]   tol_abs;
    assign tol_abs = r_a_tol[16] ? -r_a_tol : r_a_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_b_prod[3*k+j] <= $signed(rows[k][16*j +: 16]) * r_a_p[j];
                end
            end
            r_b_n   <= NW'(tol_abs[15:0]) * NW'(INV_TWO_PI_Q32);
            r_b_tol <= r_a_tol;
        end
    end

    // stage C: row sums, rounding, translation
    logic                 r_c_v;
    logic signed [LW-1:0] r_c_loc [3];
    logic [DW-1:0]        r_c_d;
    logic signed [16:0]   r_c_tol;
    logic signed [SW-1:0] row_sum [3];
    logic signed [SW-1:0] row_rnd [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            row_sum[k] = SW'(r_b_prod[3*k]) + SW'(r_b_prod[3*k+1])
                       + SW'(r_b_prod[3*k+2]) + HALF;
            row_rnd[k] = (row_sum[k] >>> ROT_FRAC) + SW'(offs[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_c_loc[k] <= LW'(row_rnd[k]);
            end
            r_c_d   <= DW'(r_b_n >> (32 - AB));
            r_c_tol <= r_b_tol;
        end
    end

    // stage D: radial bounds and squares, axial test, angle set-up
    logic signed [TW-1:0] rad_eff;
    logic [TW-2:0]        ar;
    logic [LW-1:0]        ax, ay;
    logic                 big;
    logic signed [CW-1:0] zs, ze, zlo, zhi;
    logic signed [EW-1:0] lz_e, z_min, z_max;
    logic                 ax_fail;
    logic                 neg_x;
    logic                 sat;

    always_comb begin
        rad_eff = $signed(TW'(i_radius)) + TW'(r_c_tol);
        ar      = rad_eff[TW-1] ? (TW-1)'(-rad_eff) : rad_eff[TW-2:0];
        ax      = r_c_loc[0][LW-1] ? LW'(-r_c_loc[0]) : r_c_loc[0];
        ay      = r_c_loc[1][LW-1] ? LW'(-r_c_loc[1]) : r_c_loc[1];
        big     = (MW'(ax) > MW'(ar)) || (MW'(ay) > MW'(ar));
        zs      = $signed(i_axial[CW-1:0]);
        ze      = $signed(i_axial[2*CW-1:CW]);
        zlo     = (zs > ze) ? ze : zs;
        zhi     = (zs > ze) ? zs : ze;
        lz_e    = EW'(r_c_loc[2]);
        z_min   = EW'(zlo) - EW'(r_c_tol);
        z_max   = EW'(zhi) + EW'(r_c_tol);
        ax_fail = (lz_e < z_min) || (lz_e > z_max);
        neg_x   = r_c_loc[0][LW-1];
        sat     = XW'(r_c_d) >= (XW'(i_radius) << QB);
    end

    logic                 r_d_v;
    logic                 r_d_big;
    logic [QW-1:0]        r_d_sx, r_d_sy, r_d_sr;
    logic                 r_d_axfail;
    logic signed [KW-1:0] r_d_x, r_d_y;
    logic                 r_d_neg;
    logic [DW-1:0]        r_d_d;
    logic                 r_d_tneg, r_d_tzero, r_d_sat;
    logic [TW-2:0]        ax_t, ay_t;
    assign ax_t = (TW-1)'(ax);
    assign ay_t = (TW-1)'(ay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (i_en) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_big    <= big;
            r_d_sx     <= QW'(ax_t) * QW'(ax_t);
            r_d_sy     <= QW'(ay_t) * QW'(ay_t);
            r_d_sr     <= QW'(ar) * QW'(ar);
            r_d_axfail <= ax_fail;
            r_d_x      <= neg_x ? -KW'(r_c_loc[0]) : KW'(r_c_loc[0]);
            r_d_y      <= neg_x ? -KW'(r_c_loc[1]) : KW'(r_c_loc[1]);
            r_d_neg    <= neg_x;
            r_d_d      <= r_c_d;
            r_d_tneg   <= r_c_tol[16];
            r_d_tzero  <= (r_c_tol == 17'sd0);
            r_d_sat    <= sat;
        end
    end

    // stage E: finish radial test, hand off to the angle chain
    logic         rad_fail;
    assign rad_fail = r_d_big || ((QW+1)'(r_d_sx) + (QW+1)'(r_d_sy) > (QW+1)'(r_d_sr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x   <= r_d_x;
            o_y   <= r_d_y;
            o_acc <= r_d_neg ? 32'h8000_0000 : 32'h0;
            o_rem <= r_d_d;
            o_side.verdict  <= rad_fail ? V_RADIAL : (r_d_axfail ? V_AXIAL : V_INSIDE);
            o_side.tol_neg  <= r_d_tneg;
            o_side.tol_zero <= r_d_tzero;
            o_side.sat      <= r_d_sat;
        end
    end

endmodule

// ----- design/pic_cell.sv -----
// One chain cell: a vectoring rotation step and, for IDX below AB+3, one restoring divide step.
module pic_cell #(
    parameter int CW  = pic_pkg::COORD_WIDTH_DEF,
    parameter int AB  = pic_pkg::ANGLE_BITS_DEF,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CW+5:0] i_x,
    input  logic signed [CW+5:0] i_y,
    input  logic [31:0]          i_acc,
    input  logic [AB+13:0]       i_rem,
    input  logic [AB+2:0]        i_quo,
    input  pic_pkg::t_side       i_side,
    input  logic [CW-2:0]        i_radius,
    output logic                 o_valid,
    output logic signed [CW+5:0] o_x,
    output logic signed [CW+5:0] o_y,
    output logic [31:0]          o_acc,
    output logic [AB+13:0]       o_rem,
    output logic [AB+2:0]        o_quo,
    output pic_pkg::t_side       o_side
);
    import pic_pkg::*;

    localparam int KW = CW + 6;
    localparam int DW = AB + 14;
    localparam int QB = AB + 3;
    localparam int XW = DW + CW;
    localparam bit DO_DIV = (IDX < QB);
    localparam int SH = DO_DIV ? QB - 1 - IDX : 0;
    localparam logic [31:0] ATAN = atan_turn(IDX);

    logic signed [KW-1:0] dx, dy, n_x, n_y;
    logic [31:0]          n_acc;
    logic [XW-1:0]        dsh;
    logic [DW-1:0]        n_rem;
    logic [QB-1:0]        n_quo;

    always_comb begin
        dx = i_x >>> IDX;
        dy = i_y >>> IDX;
        n_x   = i_x;
        n_y   = i_y;
        n_acc = i_acc;
        if (i_y > 0) begin
            n_x   = i_x + dy;
            n_y   = i_y - dx;
            n_acc = i_acc + ATAN;
        end else if (i_y < 0) begin
            n_x   = i_x - dy;
            n_y   = i_y + dx;
            n_acc = i_acc - ATAN;
        end
        dsh   = XW'(i_radius) << SH;
        n_rem = i_rem;
        n_quo = i_quo;
        if (DO_DIV && (XW'(i_rem) >= dsh)) begin
            n_rem     = DW'(XW'(i_rem) - dsh);
            n_quo[SH] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_acc  <= n_acc;
            o_rem  <= n_rem;
            o_quo  <= n_quo;
            o_side <= i_side;
        end
    end

endmodule

// ----- design/pic_skid.sv -----
// Output register with a one-entry skid stage; drives the pipeline advance.
module pic_skid (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_inside,
    input  logic [1:0] i_verdict,
    input  logic       i_ready,
    output logic       o_advance,
    output logic       o_valid,
    output logic       o_inside,
    output logic [1:0] o_verdict
);
    logic       r_sv;
    logic       r_s_inside;
    logic [1:0] r_s_verdict;
    logic       take;
    logic       arrive;

    assign o_advance = !r_sv;
    assign take      = o_valid && i_ready;
    assign arrive    = o_advance && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_sv    <= 1'b0;
        end else if (r_sv) begin
            if (take) begin
                r_sv <= 1'b0;
            end
        end else if (arrive) begin
            if (o_valid && !take) begin
                r_sv <= 1'b1;
            end else begin
                o_valid <= 1'b1;
            end
        end else if (take) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (take) begin
                o_inside  <= r_s_inside;
                o_verdict <= r_s_verdict;
            end
        end else if (arrive) begin
            if (o_valid && !take) begin
                r_s_inside  <= i_inside;
                r_s_verdict <= i_verdict;
            end else begin
                o_inside  <= i_inside;
                o_verdict <= i_verdict;
            end
        end
    end

endmodule

// ----- design/point_in_cylinder_sector_test.sv -----
// Pipeline: 5 front stages, 30 angle/divide cells and an output register lie
// between input transaction and result valid. Throughput: one point per cycle;
// the rate is set by the fully pipelined cell chain. A held result goes to a
// one-entry skid stage, and the input stalls only while that stage is full.
// Reset (synchronous, active low) clears all valid bits and loads the
// configuration defaults: identity frame, radius 256, open z range, full turn.
module point_in_cylinder_sector_test #(
    parameter int COORD_WIDTH = pic_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_BITS  = pic_pkg::ANGLE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // point_x, point_y, point_z, tolerance, zero fill
    input  logic [((3*COORD_WIDTH+16+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // inside_res, verdict, zero fill
    output logic [7:0] m_axis_tdata,
    input  logic i_cfg_we,
    input  logic [2:0] i_cfg_addr,
    input  logic [((3*COORD_WIDTH > 48) ? ((3*COORD_WIDTH > 2*ANGLE_BITS+2) ?
                   3*COORD_WIDTH : 2*ANGLE_BITS+2) : ((48 > 2*ANGLE_BITS+2) ?
                   48 : 2*ANGLE_BITS+2))-1:0] i_cfg_data
);
    import pic_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int AB = ANGLE_BITS;
    localparam int KW = CW + 6;
    localparam int DW = AB + 14;
    localparam int QB = AB + 3;
    localparam int AW = AB + 6;
    localparam int NS = CORDIC_STEPS;

    // configuration registers
    logic [47:0]       r_row0, r_row1, r_row2;
    logic [3*CW-1:0]   r_offset;
    logic [CW-2:0]     r_radius;
    logic [2*CW-1:0]   r_axial;
    logic [2*AB+1:0]   r_sector;
    logic              r_exclude;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0    <= 48'h0000_0000_4000;
            r_row1    <= 48'h0000_4000_0000;
            r_row2    <= 48'h4000_0000_0000;
            r_offset  <= '0;
            r_radius  <= (CW-1)'(256);
            r_axial   <= {1'b0, {(CW-1){1'b1}}, 1'b1, {(CW-1){1'b0}}};
            r_sector  <= {1'b1, {AB{1'b0}}, {(AB+1){1'b0}}};
            r_exclude <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ROW0:    r_row0    <= i_cfg_data[47:0];
                REG_ROW1:    r_row1    <= i_cfg_data[47:0];
                REG_ROW2:    r_row2    <= i_cfg_data[47:0];
                REG_OFFSET:  r_offset  <= i_cfg_data[3*CW-1:0];
                REG_RADIUS:  r_radius  <= i_cfg_data[CW-2:0];
                REG_AXIAL:   r_axial   <= i_cfg_data[2*CW-1:0];
                REG_SECTOR:  r_sector  <= i_cfg_data[2*AB+1:0];
                REG_EXCLUDE: r_exclude <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic advance;
    assign s_axis_tready = advance;

    // chain wiring
    logic                 c_v    [0:NS];
    logic signed [KW-1:0] c_x    [0:NS];
    logic signed [KW-1:0] c_y    [0:NS];
    logic [31:0]          c_acc  [0:NS];
    logic [DW-1:0]        c_rem  [0:NS];
    logic [QB-1:0]        c_quo  [0:NS];
    t_side                c_side [0:NS];

    assign c_quo[0] = '0;

    pic_front #(.CW(CW), .AB(AB)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_valid   (s_axis_tvalid),
        .i_px      ($signed(s_axis_tdata[CW-1:0])),
        .i_py      ($signed(s_axis_tdata[2*CW-1:CW])),
        .i_pz      ($signed(s_axis_tdata[3*CW-1:2*CW])),
        .i_tol     ($signed(s_axis_tdata[3*CW+15:3*CW])),
        .i_row0    (r_row0),
        .i_row1    (r_row1),
        .i_row2    (r_row2),
        .i_offset  (r_offset),
        .i_radius  (r_radius),
        .i_axial   (r_axial),
        .i_exclude (r_exclude),
        .o_valid   (c_v[0]),
        .o_x       (c_x[0]),
        .o_y       (c_y[0]),
        .o_acc     (c_acc[0]),
        .o_rem     (c_rem[0]),
        .o_side    (c_side[0])
    );

    for (genvar g = 0; g < NS; g++) begin : g_cell
        pic_cell #(.CW(CW), .AB(AB), .IDX(g)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (advance),
            .i_valid  (c_v[g]),
            .i_x      (c_x[g]),
            .i_y      (c_y[g]),
            .i_acc    (c_acc[g]),
            .i_rem    (c_rem[g]),
            .i_quo    (c_quo[g]),
            .i_side   (c_side[g]),
            .i_radius (r_radius),
            .o_valid  (c_v[g+1]),
            .o_x      (c_x[g+1]),
            .o_y      (c_y[g+1]),
            .o_acc    (c_acc[g+1]),
            .o_rem    (c_rem[g+1]),
            .o_quo    (c_quo[g+1]),
            .o_side   (c_side[g+1])
        );
    end

    // angular test and final verdict
    logic [AB:0]          a1r, a2r, a1u, a2u, span;
    logic signed [AW-1:0] ang, a1, a2, mag, da, lo, hi;
    logic [1:0]           verdict;
    t_side                fs;

    always_comb begin
        fs   = c_side[NS];
        a1r  = r_sector[AB:0];
        a2r  = r_sector[2*AB+1:AB+1];
        a1u  = (a1r > a2r) ? a2r : a1r;
        a2u  = (a1r > a2r) ? a1r : a2r;
        span = a2u - a1u;
        ang  = $signed(AW'(c_acc[NS][31 -: AB]));
        a1   = $signed(AW'(a1u));
        a2   = $signed(AW'(a2u));
        // saturated quotient stands for any widening beyond the angle range
        mag  = fs.sat ? $signed(AW'(1) << QB) : $signed(AW'(c_quo[NS]));
        da   = fs.tol_zero ? '0 : (fs.tol_neg ? -mag : mag);
        lo   = a1 - da;
        hi   = a2 + da;
        verdict = fs.verdict;
        if (fs.verdict == V_INSIDE && !span[AB]) begin
            if (r_radius == '0 && !fs.tol_zero) begin
                verdict = fs.tol_neg ? V_ANGULAR : V_INSIDE;
            end else if (ang < lo || ang > hi) begin
                verdict = V_ANGULAR;
            end
        end
    end

    logic       out_inside;
    logic [1:0] out_verdict;

    pic_skid u_skid (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (c_v[NS]),
        .i_inside  (verdict == V_INSIDE),
        .i_verdict (verdict),
        .i_ready   (m_axis_tready),
        .o_advance (advance),
        .o_valid   (m_axis_tvalid),
        .o_inside  (out_inside),
        .o_verdict (out_verdict)
    );

    assign m_axis_tdata = {5'b0, out_verdict, out_inside};

endmodule
